// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the LCD write sequencer RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must hold on every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) \
        else $error("assertion failed");

// Antecedent implies consequent in the same cycle
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: hw/rtl/lcds_pkg.sv
// Package for the LCD 4-bit write sequencer: word types, opcodes, timing
// constants and the fixed init and glyph tables. No dependencies.
`default_nettype none

package lcds_pkg;

    // Display geometry
    localparam int COLUMNS = 16;

    // Byte queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // Phase hold times in ms
    localparam logic [4:0] HOLD_EN_MS    = 5'd1;
    localparam logic [4:0] HOLD_SETUP_MS = 5'd5;
    localparam logic [4:0] HOLD_TAIL_MS  = 5'd6;

    // Command bytes and address bases
    localparam logic [7:0] ROW1_BASE    = 8'h80;
    localparam logic [7:0] ROW2_BASE    = 8'hC0;
    localparam logic [7:0] ROW3_BASE    = 8'h80 | 8'h14;
    localparam logic [7:0] ROW4_BASE    = 8'h80 | 8'h54;
    localparam logic [7:0] CGRAM_BASE   = 8'h40;
    localparam logic [7:0] ASCII_ZERO   = 8'h30;

    // Request opcodes
    typedef enum logic [2:0] {
        OP_INIT  = 3'd0,
        OP_CMD   = 3'd1,
        OP_DATA  = 3'd2,
        OP_GOTO  = 3'd3,
        OP_NUM   = 3'd4,
        OP_GLYPH = 3'd5
    } t_opcode;

    // Power-up command sequence and extra settle time on its last phase
    localparam int INIT_LEN = 9;
    localparam logic [7:0] INIT_BYTES [0:INIT_LEN-1] = '{
        8'h03, 8'h03, 8'h03, 8'h02, 8'h28, 8'h08, 8'h01, 8'h06, 8'h0C
    };
    localparam logic [4:0] INIT_EXTRA [0:INIT_LEN-1] = '{
        5'd4, 5'd4, 5'd4, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd20
    };

    // Fixed custom glyph patterns, eight rows per slot
    localparam logic [7:0] GLYPH_ROWS [0:7][0:7] = '{
        '{8'h00, 8'h0A, 8'h15, 8'h11, 8'h0A, 8'h04, 8'h00, 8'h00},
        '{8'h04, 8'h1F, 8'h11, 8'h11, 8'h1F, 8'h1F, 8'h1F, 8'h1F},
        '{8'h04, 8'h0E, 8'h0E, 8'h0E, 8'h1F, 8'h00, 8'h04, 8'h00},
        '{8'h01, 8'h03, 8'h07, 8'h1F, 8'h1F, 8'h07, 8'h03, 8'h01},
        '{8'h01, 8'h03, 8'h05, 8'h09, 8'h09, 8'h0B, 8'h1B, 8'h18},
        '{8'h0A, 8'h0A, 8'h1F, 8'h11, 8'h11, 8'h0E, 8'h04, 8'h04},
        '{8'h00, 8'h00, 8'h0A, 8'h00, 8'h04, 8'h11, 8'h0E, 8'h00},
        '{8'h00, 8'h0A, 8'h1F, 8'h1F, 8'h0E, 8'h04, 8'h00, 8'h00}
    };

    // Request word
    typedef struct packed {
        logic [2:0]  opcode;
        logic [7:0]  byte_value;
        logic [15:0] number;
        logic [2:0]  row;
        logic [4:0]  column;
        logic [2:0]  glyph_slot;
    } t_req;

    // Pin phase word
    typedef struct packed {
        logic       reg_select;
        logic       enable;
        logic [3:0] nibble;
        logic [4:0] hold_ms;
        logic       last;
    } t_phase;

    // One LCD byte queued between front and back
    typedef struct packed {
        logic       rs;
        logic [7:0] value;
        logic [4:0] extra;
        logic       last;
    } t_byte_word;

    // Queue status toward the producer and consumer
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

`default_nettype wire

// File: hw/rtl/lcd_4bit_write_sequencer.sv
// LCD 4-bit write sequencer: a request front expands each request into bytes,
// a 4-entry byte queue decouples it, and a pin back emits one phase per cycle.
// A request reaches the pins via the front state, the queue and the back phase state.
// Each request expands into 1 to 9 LCD bytes; the back sets the pace.
// The front runs ahead by the queue depth; busy drops while the last byte is queued.
// Synchronous active-low reset clears control state; output strobes are not stallable.
`default_nettype none

module lcd_4bit_write_sequencer
    import lcds_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   start,
    output logic        busy,
    input  t_req        i_req,
    output logic        o_strobe,
    output t_phase      o_res
);

    t_q_status      q_status;
    t_byte_word     push_word;
    t_byte_word     pop_word;
    logic           push;
    logic           pop;

    lcds_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .o_busy     (busy),
        .i_req      (i_req),
        .i_q_status (q_status),
        .o_push     (push),
        .o_word     (push_word)
    );

    lcds_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_word     (push_word),
        .i_pop      (pop),
        .o_word     (pop_word),
        .o_status   (q_status)
    );

    lcds_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_word     (pop_word),
        .i_q_status (q_status),
        .o_pop      (pop),
        .o_strobe   (o_strobe),
        .o_res      (o_res)
    );

endmodule

`default_nettype wire

// File: hw/rtl/lcds_fifo.sv
// Small byte queue that decouples the request front from the pin back.
// Depends on lcds_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module lcds_fifo
    import lcds_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_push,
    input  t_byte_word      i_word,
    input  wire logic       i_pop,
    output t_byte_word      o_word,
    output t_q_status       o_status
);

    t_byte_word              r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]     r_wr;
    logic [QUEUE_AW-1:0]     r_rd;
    logic [QUEUE_AW:0]       r_cnt;
    logic [QUEUE_AW:0]       n_cnt;

    // Storage write
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_word;
        end
    end

    // Occupancy
    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    // Pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= n_cnt;
        end
    end

    assign o_word          = r_mem[r_rd];
    assign o_status.full   = (r_cnt == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_status.empty  = (r_cnt == '0);

    `ASSERT_IMPL(a_no_overflow, i_clk, i_rst_n, i_push, !o_status.full)
    `ASSERT_IMPL(a_no_underflow, i_clk, i_rst_n, i_pop, !o_status.empty)

endmodule

`default_nettype wire

// File: hw/rtl/lcds_front.sv
// Request front: accepts requests, classifies them and expands each into LCD
// bytes pushed one per cycle into the queue while it is not full. Depends on lcds_pkg, assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module lcds_front
    import lcds_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_start,
    output logic            o_busy,
    input  t_req            i_req,
    input  t_q_status       i_q_status,
    output logic            o_push,
    output t_byte_word      o_word
);

    typedef enum logic [1:0] {
        FS_IDLE = 2'b01,
        FS_RUN  = 2'b10
    } t_front_state;

    t_front_state   r_state;
    t_front_state   n_state;
    t_opcode        r_op;
    logic [3:0]     r_idx;
    logic [3:0]     r_end;
    logic [7:0]     r_bval;
    logic [7:0]     r_addr;
    logic [13:0]    r_num;
    logic [2:0]     r_slot;

    logic           acc;
    logic           req_valid;
    logic [3:0]     req_first;
    logic [3:0]     req_end;
    logic [7:0]     goto_base;
    logic [3:0]     dig;
    logic [13:0]    num_rem;
    t_byte_word     word;

    // Low four decimal digits of a 16-bit value
    function automatic logic [13:0] mod_10k(input logic [15:0] n);
        logic [15:0] r;
        r = n;
        for (int k = 1; k <= 6; k++) begin
            if (n >= 16'(k * 10000)) begin
                r = n - 16'(k * 10000);
            end
        end
        return r[13:0];
    endfunction

    // Leading digit of v for a given decimal place
    function automatic logic [3:0] dec_digit(input logic [13:0] v, input logic [13:0] place);
        logic [3:0] d;
        d = '0;
        for (int k = 1; k <= 9; k++) begin
            if (v >= 14'(k) * place) begin
                d = 4'(k);
            end
        end
        return d;
    endfunction

    // Classify the incoming request
    always_comb begin
        req_valid = 1'b0;
        req_first = '0;
        req_end   = '0;
        goto_base = ROW1_BASE;
        case (i_req.row)
            3'd1: goto_base = ROW1_BASE;
            3'd2: goto_base = ROW2_BASE;
            3'd3: goto_base = ROW3_BASE;
            3'd4: goto_base = ROW4_BASE;
            default: goto_base = ROW1_BASE;
        endcase
        case (t_opcode'(i_req.opcode))
            OP_INIT: begin
                req_valid = 1'b1;
                req_end   = 4'(INIT_LEN - 1);
            end
            OP_CMD, OP_DATA: begin
                req_valid = 1'b1;
            end
            OP_GOTO: begin
                req_valid = (i_req.column < 5'(COLUMNS)) &&
                            (i_req.row >= 3'd1) && (i_req.row <= 3'd4);
            end
            OP_NUM: begin
                req_valid = 1'b1;
                req_end   = 4'd3;
                if (i_req.number >= 16'd1000) begin
                    req_first = 4'd0;
                end else if (i_req.number >= 16'd100) begin
                    req_first = 4'd1;
                end else if (i_req.number >= 16'd10) begin
                    req_first = 4'd2;
                end else begin
                    req_first = 4'd3;
                end
            end
            OP_GLYPH: begin
                req_valid = 1'b1;
                req_end   = 4'd8;
            end
            default: begin
                req_valid = 1'b0;
            end
        endcase
    end

    // Current decimal digit and the remainder left for the next place
    always_comb begin
        case (r_idx[1:0])
            2'd0: begin
                dig     = dec_digit(r_num, 14'd1000);
                num_rem = r_num - 14'(dig) * 14'd1000;
            end
            2'd1: begin
                dig     = dec_digit(r_num, 14'd100);
                num_rem = r_num - 14'(dig) * 14'd100;
            end
            2'd2: begin
                dig     = dec_digit(r_num, 14'd10);
                num_rem = r_num - 14'(dig) * 14'd10;
            end
            default: begin
                dig     = r_num[3:0];
                num_rem = '0;
            end
        endcase
    end

    // Byte for the current step
    always_comb begin
        word       = '0;
        word.last  = (r_idx == r_end);
        case (r_op)
            OP_INIT: begin
                word.value = INIT_BYTES[r_idx];
                word.extra = INIT_EXTRA[r_idx];
            end
            OP_CMD: begin
                word.value = r_bval;
            end
            OP_DATA: begin
                word.rs    = 1'b1;
                word.value = r_bval;
            end
            OP_GOTO: begin
                word.value = r_addr;
            end
            OP_NUM: begin
                word.rs    = 1'b1;
                word.value = ASCII_ZERO + {4'b0, dig};
            end
            OP_GLYPH: begin
                if (r_idx == '0) begin
                    word.value = CGRAM_BASE + {2'b0, r_slot, 3'b0};
                end else begin
                    word.rs    = 1'b1;
                    word.value = GLYPH_ROWS[r_slot][3'(r_idx - 4'd1)];
                end
            end
            default: begin
                word.value = '0;
            end
        endcase
    end

    // Handshake
    assign o_push = (r_state == FS_RUN) && !i_q_status.full;
    assign o_busy = (r_state == FS_RUN) && !(o_push && word.last);
    assign o_word = word;
    assign acc    = i_start && !o_busy;

    // Sequencer state
    always_comb begin
        n_state = r_state;
        if (acc) begin
            n_state = req_valid ? FS_RUN : FS_IDLE;
        end else if (o_push && word.last) begin
            n_state = FS_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Request payload and step index
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_op   <= t_opcode'(i_req.opcode);
            r_idx  <= req_first;
            r_end  <= req_end;
            r_bval <= i_req.byte_value;
            r_addr <= goto_base + {3'b0, i_req.column};
            r_num  <= mod_10k(i_req.number);
            r_slot <= i_req.glyph_slot;
        end else if (o_push) begin
            r_idx  <= r_idx + 1'b1;
            r_num  <= num_rem;
        end
    end

    `ASSERT_NEXT(a_accept_runs, i_clk, i_rst_n, acc && req_valid, r_state == FS_RUN)

endmodule

`default_nettype wire

// File: hw/rtl/lcds_back.sv
// Pin back: takes queued LCD bytes and drives four pin phases per byte,
// one phase per cycle. Depends on lcds_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module lcds_back
    import lcds_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  t_byte_word      i_word,
    input  t_q_status       i_q_status,
    output logic            o_pop,
    output logic            o_strobe,
    output t_phase          o_res
);

    typedef enum logic [3:0] {
        PH_HI_EN = 4'b0001,
        PH_HI    = 4'b0010,
        PH_LO_EN = 4'b0100,
        PH_LO    = 4'b1000
    } t_phase_state;

    t_phase_state   r_state;
    t_phase_state   n_state;
    logic           r_has;
    logic           n_has;
    t_byte_word     r_cur;

    // Take the next byte when idle or on the final phase of the current one
    assign o_pop = !i_q_status.empty && (!r_has || (r_state == PH_LO));

    always_comb begin
        n_state = r_state;
        n_has   = r_has;
        if (o_pop) begin
            n_state = PH_HI_EN;
            n_has   = 1'b1;
        end else if (r_has) begin
            case (r_state)
                PH_HI_EN: n_state = PH_HI;
                PH_HI:    n_state = PH_LO_EN;
                PH_LO_EN: n_state = PH_LO;
                PH_LO: begin
                    n_state = PH_HI_EN;
                    n_has   = 1'b0;
                end
                default:  n_state = PH_HI_EN;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= PH_HI_EN;
            r_has   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_has   <= n_has;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cur <= i_word;
        end
    end

    // Pin levels for the current phase
    always_comb begin
        o_res            = '0;
        o_res.reg_select = r_cur.rs;
        case (r_state)
            PH_HI_EN: begin
                o_res.enable  = 1'b1;
                o_res.nibble  = r_cur.value[7:4];
                o_res.hold_ms = HOLD_EN_MS;
            end
            PH_HI: begin
                o_res.nibble  = r_cur.value[7:4];
                o_res.hold_ms = HOLD_SETUP_MS;
            end
            PH_LO_EN: begin
                o_res.enable  = 1'b1;
                o_res.nibble  = r_cur.value[3:0];
                o_res.hold_ms = HOLD_EN_MS;
            end
            PH_LO: begin
                o_res.nibble  = r_cur.value[3:0];
                o_res.hold_ms = HOLD_TAIL_MS + r_cur.extra;
                o_res.last    = r_cur.last;
            end
            default: begin
                o_res.hold_ms = HOLD_EN_MS;
            end
        endcase
    end

    assign o_strobe = r_has;

    `ASSERT_IMPL(a_last_on_low, i_clk, i_rst_n, o_strobe && o_res.last, !o_res.enable)
    `ASSERT_NEXT(a_en_pulse, i_clk, i_rst_n, o_strobe && o_res.enable,
        o_strobe && !o_res.enable && $stable(o_res.nibble))

endmodule

`default_nettype wire
